>>> sv/rmf_pkg.sv
// rmf_pkg: shared types and constants for the rgb 3x3 median filter
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package rmf_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int SIZE       = 9;
    localparam int MID        = 4;
    localparam int Q_DEPTH    = 4;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [23:0] pix_t;

    // source of a released output within the window
    typedef enum logic [1:0] {
        SRC_CENTER = 2'd0,
        SRC_RIGHT  = 2'd1,
        SRC_BELOW  = 2'd2,
        SRC_CORNER = 2'd3
    } src_t;

    // one queued job: a window snapshot plus release plan
    typedef struct packed {
        pix_t [SIZE-1:0] win;
        logic [3:0]      en;       // which of the four outputs exist
        logic            interior; // center output is a median
        logic [3:0]      fend;     // frame end flags per output
    } job_t;

    // sort two 8-bit values
    function automatic logic [15:0] cas(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] r;
        r = (a > b) ? {a, b} : {b, a};
        return r; // {hi, lo}
    endfunction
endpackage
`default_nettype wire

>>> sv/rmf_front.sv
// rmf_front: position counters, line stores, window, release planning
// depends on rmf_pkg
`timescale 1ns / 1ps
`default_nettype none
module rmf_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire rmf_pkg::pix_t           in_pix,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_index,
    input  wire logic                    cfg_hit,
    input  wire logic [23:0]             cfg_data,
    output logic                         job_valid,
    input  wire logic                    job_ready,
    output rmf_pkg::job_t                job
);
    import rmf_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W:0]      w_eff;
    logic [ROW_W:0]      h_eff;
    logic                take;

    pix_t upper_mem [MAX_WIDTH];
    pix_t lower_mem [MAX_WIDTH];
    pix_t up_rd, lo_rd;

    // stage 1 holds the pixel while the stores are read
    logic               s1_valid_reg;
    pix_t               s1_pix_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;

    pix_t [SIZE-1:0]    win_reg;
    logic               jv_reg;
    job_t               job_reg;
    logic               s1_go;
    logic               advance;
    logic [COL_W:0]     c_next;

    always_comb begin
        w_eff = (width_reg < 12'd3) ? (COL_W+1)'(3) :
                (width_reg > WIDTH_W'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) :
                (COL_W+1)'(width_reg);
        h_eff = (height_reg < 13'd3) ? (ROW_W+1)'(3) :
                (height_reg > HEIGHT_W'(MAX_HEIGHT)) ? (ROW_W+1)'(MAX_HEIGHT) :
                (ROW_W+1)'(height_reg);
    end

    // pipeline moves when the job slot is free
    assign advance  = !jv_reg || job_ready;
    assign in_ready = advance && !cfg_valid;
    assign take     = in_valid && in_ready;
    assign s1_go    = s1_valid_reg && advance;
    assign c_next   = (COL_W+1)'(col_reg) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_valid && cfg_hit) begin
            if (cfg_index == CFG_WIDTH) width_reg <= cfg_data[WIDTH_W-1:0];
            else                        height_reg <= cfg_data[HEIGHT_W-1:0];
            col_reg <= '0;
            row_reg <= '0;
        end else if (take) begin
            if (c_next >= w_eff) begin
                col_reg <= '0;
                row_reg <= ((ROW_W+1)'(row_reg) + 1'b1 >= h_eff) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= c_next[COL_W-1:0];
            end
        end
    end

    // line stores: registered read at accept, lower row written at once,
    // upper row takes the registered lower read when stage 1 moves on
    always_ff @(posedge aclk) begin
        if (take) begin
            up_rd <= upper_mem[col_reg];
            lo_rd <= lower_mem[col_reg];
            lower_mem[col_reg] <= in_pix;
        end
        if (s1_go) begin
            upper_mem[s1_col_reg] <= lo_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= take;
        end
        if (take) begin
            s1_pix_reg <= in_pix;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    // window shift and release plan
    logic       has_up, is_lastr, has_left, is_lastc;
    logic [COL_W:0] cx;
    logic [ROW_W:0] ry;
    pix_t [SIZE-1:0] win_next;
    always_comb begin
        cx       = (COL_W+1)'(s1_col_reg);
        ry       = (ROW_W+1)'(s1_row_reg);
        has_up   = ry >= 1;
        is_lastr = ry == h_eff - 1'b1;
        has_left = cx >= 1;
        is_lastc = cx == w_eff - 1'b1;
        win_next = win_reg;
        win_next[0] = win_reg[1]; win_next[1] = win_reg[2]; win_next[2] = up_rd;
        win_next[3] = win_reg[4]; win_next[4] = win_reg[5]; win_next[5] = lo_rd;
        win_next[6] = win_reg[7]; win_next[7] = win_reg[8]; win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jv_reg  <= 1'b0;
            win_reg <= '0;
        end else if (advance) begin
            jv_reg <= s1_go;
            if (s1_go) begin
                win_reg <= win_next;
            end
        end
        if (s1_go) begin
            job_reg.win      <= win_next;
            // order: (up,left) (up,cur) (cur,left) (cur,cur)
            job_reg.en       <= {is_lastr & is_lastc, is_lastr & has_left,
                                 has_up & is_lastc, has_up & has_left};
            job_reg.interior <= (cx >= 2) && (ry >= 2) && (ry - 1'b1 <= h_eff - 2'd2);
            // only the bottom-right pixel closes the frame
            job_reg.fend     <= {is_lastr & is_lastc, 3'b000};
        end
    end

    assign job_valid = jv_reg;
    assign job       = job_reg;
endmodule
`default_nettype wire

>>> sv/rmf_queue.sv
// rmf_queue: small fifo of planned jobs between front and back
// depends on rmf_pkg
`timescale 1ns / 1ps
`default_nettype none
module rmf_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire rmf_pkg::job_t wr_job,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output rmf_pkg::job_t      rd_job
);
    import rmf_pkg::*;
    localparam int PW = $clog2(Q_DEPTH);
    job_t            q_reg [Q_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            wr, rd;

    assign wr_ready = cnt_reg != (PW+1)'(Q_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_job = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);
        end
        if (wr) q_reg[wp_reg] <= wr_job;
    end
endmodule
`default_nettype wire

>>> sv/rmf_back.sv
// rmf_back: median networks and sequencing of released outputs
// depends on rmf_pkg
`timescale 1ns / 1ps
`default_nettype none
module rmf_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire rmf_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rmf_pkg::pix_t      out_pix,
    output logic               out_last,
    output logic               out_fend
);
    import rmf_pkg::*;

    // stage a: per-row sort of the 3x3 window (three rows sorted)
    logic          a_valid_reg;
    job_t          a_job_reg;
    logic [7:0]    a_s [3][9];  // per channel, rows sorted lo,mid,hi
    // stage b: median of sorted rows
    logic          b_valid_reg;
    job_t          b_job_reg;
    pix_t          b_med_reg;
    logic [3:0]    b_left_reg;  // outputs still to emit
    logic          out_v_reg;
    pix_t          out_pix_reg;
    logic          out_last_reg, out_fend_reg;
    logic          b_done, b_emit, stall_out;
    logic [3:0]    pick, left_after;
    logic [7:0]    a_next [3][9];
    logic [7:0]    med_ch [3];

    function automatic logic [23:0] sort3(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] z);
        logic [15:0] p, q, r;
        p = cas(x, y);
        q = cas(p[15:8], z);
        r = cas(p[7:0], q[7:0]);
        return {q[15:8], r[15:8], r[7:0]};
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] z);
        logic [23:0] s;
        s = sort3(x, y, z);
        return s[15:8];
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                logic [23:0] s;
                s = sort3(job.win[r*3][ch*8 +: 8], job.win[r*3+1][ch*8 +: 8],
                          job.win[r*3+2][ch*8 +: 8]);
                a_next[ch][r*3]   = s[7:0];
                a_next[ch][r*3+1] = s[15:8];
                a_next[ch][r*3+2] = s[23:16];
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            logic [7:0] mx_lo, mn_hi, md;
            mx_lo = a_s[ch][0] > a_s[ch][3] ? a_s[ch][0] : a_s[ch][3];
            mx_lo = mx_lo > a_s[ch][6] ? mx_lo : a_s[ch][6];
            mn_hi = a_s[ch][2] < a_s[ch][5] ? a_s[ch][2] : a_s[ch][5];
            mn_hi = mn_hi < a_s[ch][8] ? mn_hi : a_s[ch][8];
            md    = med3(a_s[ch][1], a_s[ch][4], a_s[ch][7]);
            med_ch[ch] = med3(mx_lo, md, mn_hi);
        end
    end

    // emitter: one output per cycle from b while the output is not stalled
    assign stall_out  = out_v_reg && !out_ready;
    always_comb begin
        pick = '0;
        if      (b_left_reg[0]) pick = 4'b0001;
        else if (b_left_reg[1]) pick = 4'b0010;
        else if (b_left_reg[2]) pick = 4'b0100;
        else if (b_left_reg[3]) pick = 4'b1000;
    end
    assign left_after = b_left_reg & ~pick;
    assign b_emit = b_valid_reg && !stall_out && (b_left_reg != '0);
    assign b_done = !b_valid_reg || (!stall_out && left_after == '0);
    wire a_move = b_done;
    assign job_ready = !a_valid_reg || a_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            out_v_reg   <= 1'b0;
            b_left_reg  <= '0;
        end else begin
            if (job_ready) a_valid_reg <= job_valid;
            if (a_move) begin
                b_valid_reg <= a_valid_reg && (a_job_reg.en != '0);
                b_left_reg  <= a_job_reg.en;
            end else if (b_emit) begin
                b_left_reg <= left_after;
            end
            if (!stall_out) out_v_reg <= b_emit;
        end
        if (job_ready) begin
            a_job_reg <= job;
            a_s       <= a_next;
        end
        if (a_move) begin
            b_job_reg <= a_job_reg;
            b_med_reg <= {med_ch[2], med_ch[1], med_ch[0]};
        end
        if (b_emit) begin
            unique case (1'b1)
                pick[0]: out_pix_reg <= b_job_reg.interior ? b_med_reg : b_job_reg.win[4];
                pick[1]: out_pix_reg <= b_job_reg.win[5];
                pick[2]: out_pix_reg <= b_job_reg.win[7];
                default: out_pix_reg <= b_job_reg.win[8];
            endcase
            out_last_reg <= left_after == '0;
            out_fend_reg <= |(pick & b_job_reg.fend);
        end
    end

    assign out_valid = out_v_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;
    assign out_fend  = out_fend_reg;
endmodule
`default_nettype wire

>>> sv/rgb_median_filter_3x3.sv
// rgb_median_filter_3x3: top level of the streaming rgb 3x3 median filter
// depends on rmf_pkg, rmf_front, rmf_queue, rmf_back
`timescale 1ns / 1ps
`default_nettype none
// Streaming per-channel 3x3 median over raster-order rgb pixels. One pixel
// is accepted per cycle unless stalled; each output leaves the result
// register one per cycle while m_ready is high, so the sustained rate is
// one transaction per cycle except where an input releases more than one
// output (row ends and the last row), where the job queue absorbs the
// extra outputs. The limit is the single output register of the back end.
// Border pixels pass through unchanged. Writing width or height restarts
// the frame; line stores are not cleared and need no clearing pass.
module rgb_median_filter_3x3 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_red,
    input  wire logic [7:0]  s_in_green,
    input  wire logic [7:0]  s_in_blue,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic             m_last_of_run,
    output logic             m_frame_end
);
    import rmf_pkg::*;

    logic  fj_valid, fj_ready, bj_valid, bj_ready;
    job_t  fj, bj;
    pix_t  opix;
    logic  cfg_hit;

    // config is always taken; only indexes 0 and 1 touch state
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_index[31:1] == '0;

    rmf_front u_front (
        .aclk, .aresetn,
        .in_valid (s_valid), .in_ready (s_ready),
        .in_pix   ({s_in_blue, s_in_green, s_in_red}),
        .cfg_valid, .cfg_index (cfg_index[0]), .cfg_hit,
        .cfg_data (cfg_data[23:0]),
        .job_valid (fj_valid), .job_ready (fj_ready), .job (fj)
    );

    rmf_queue u_queue (
        .aclk, .aresetn,
        .wr_valid (fj_valid), .wr_ready (fj_ready), .wr_job (fj),
        .rd_valid (bj_valid), .rd_ready (bj_ready), .rd_job (bj)
    );

    rmf_back u_back (
        .aclk, .aresetn,
        .job_valid (bj_valid), .job_ready (bj_ready), .job (bj),
        .out_valid (m_valid), .out_ready (m_ready), .out_pix (opix),
        .out_last (m_last_of_run), .out_fend (m_frame_end)
    );

    assign m_out_red   = opix[7:0];
    assign m_out_green = opix[15:8];
    assign m_out_blue  = opix[23:16];
endmodule
`default_nettype wire

>>> sv/rmf_checker.sv
// rmf_checker: port-level checks for the median filter, bound to the top
// depends on rgb_median_filter_3x3 as the bind target
`timescale 1ns / 1ps
`default_nettype none
module rmf_port_checks (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_red,
    input wire logic       m_last_of_run,
    input wire logic       m_frame_end
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red))
        else $error("output dropped while stalled");
    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_last_of_run)
        else $error("frame end not last of run");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
endmodule

bind rgb_median_filter_3x3 rmf_port_checks u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_out_red, .m_last_of_run, .m_frame_end
);
`default_nettype wire

>>> sim/rmf_checker.sv
// rmf_checker: watches the rgb median filter channels, predicts every output pixel and compares
// depends on rmf_pkg for the pixel type and the register indexes
`timescale 1ns / 1ps
module rmf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_red,
    input  logic [7:0]  m_out_green,
    input  logic [7:0]  m_out_blue,
    input  logic        m_last_of_run,
    input  logic        m_frame_end,
    output int          fail_count,
    output int          pending
);
    import rmf_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       fend;
    } out_pixel_t;

    out_pixel_t expected_pixels[$];

    pix_t                upper_row[MAX_WIDTH];
    pix_t                lower_row[MAX_WIDTH];
    pix_t                win[SIZE];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    function automatic logic [7:0] median_of_nine(input logic [7:0] v[SIZE]);
        logic [7:0] s[SIZE];
        logic [7:0] t;
        s = v;
        for (int i = 0; i < SIZE; i++)
            for (int j = 0; j < SIZE - 1 - i; j++)
                if (s[j] > s[j+1]) begin
                    t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                end
        return s[MID];
    endfunction

    function automatic pix_t window_median();
        logic [7:0] ch[SIZE];
        pix_t       m;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < SIZE; i++) ch[i] = win[i][8*k +: 8];
            m[8*k +: 8] = median_of_nine(ch);
        end
        return m;
    endfunction

    // advance the filter by one pixel and queue the outputs it releases
    task automatic predict_pixel(input pix_t px);
        int unsigned w, h, c, r, x, y, n;
        int unsigned ys[2], xs[2];
        bit          ycur[2], xcur[2];
        int          ny, nx;
        pix_t        up, lo, v;
        out_pixel_t  o;
        bit          interior;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        up = upper_row[c];
        lo = lower_row[c];
        win[0] = win[1]; win[1] = win[2]; win[2] = up;
        win[3] = win[4]; win[4] = win[5]; win[5] = lo;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;
        upper_row[c] = lo;
        lower_row[c] = px;
        ny = 0; nx = 0;
        if (r >= 1)     begin ys[ny] = r - 1; ycur[ny] = 0; ny++; end
        if (r == h - 1) begin ys[ny] = r;     ycur[ny] = 1; ny++; end
        if (c >= 1)     begin xs[nx] = c - 1; xcur[nx] = 0; nx++; end
        if (c == w - 1) begin xs[nx] = c;     xcur[nx] = 1; nx++; end
        n = ny * nx;
        for (int i = 0; i < ny; i++)
            for (int j = 0; j < nx; j++) begin
                x = xs[j];
                y = ys[i];
                if (!ycur[i] && !xcur[j]) begin
                    interior = x >= 1 && x <= w - 2 && y >= 1 && y <= h - 2;
                    v = interior ? window_median() : win[4];
                end else if (!ycur[i]) begin
                    v = win[5];
                end else if (!xcur[j]) begin
                    v = win[7];
                end else begin
                    v = win[8];
                end
                o.red   = v[7:0];
                o.green = v[15:8];
                o.blue  = v[23:16];
                o.last  = (i * nx + j == n - 1);
                o.fend  = (x == w - 1 && y == h - 1);
                expected_pixels.push_back(o);
            end
        c++;
        if (c == w) begin
            c = 0;
            r++;
            if (r == h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge aclk) begin
        out_pixel_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
            for (int i = 0; i < SIZE; i++) win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = 640;
            height_reg = 480;
            expected_pixels.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WIDTH) begin
                    width_reg = cfg_data[WIDTH_W-1:0];
                    col_pos = 0; row_pos = 0;
                end else if (cfg_index == CFG_HEIGHT) begin
                    height_reg = cfg_data[HEIGHT_W-1:0];
                    col_pos = 0; row_pos = 0;
                end
            end
            if (s_valid && s_ready)
                predict_pixel({s_in_blue, s_in_green, s_in_red});
            if (m_valid && m_ready) begin
                got = {m_out_red, m_out_green, m_out_blue, m_last_of_run, m_frame_end};
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output, actual r=%0d g=%0d b=%0d last=%0b fend=%0b",
                             $time, got.red, got.green, got.blue, got.last, got.fend);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected r=%0d g=%0d b=%0d last=%0b fend=%0b",
                                 $time, want.red, want.green, want.blue, want.last, want.fend,
                                 " actual r=%0d g=%0d b=%0d last=%0b fend=%0b",
                                 got.red, got.green, got.blue, got.last, got.fend);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_pixels.size();
    end
endmodule

>>> sim/tb_top.sv
// tb_top: stimulus and verdict for the rgb 3x3 median filter
// depends on rmf_pkg, rgb_median_filter_3x3 and rmf_checker
`timescale 1ns / 1ps
module tb_top;
    import rmf_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 20;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_in_red = 0;
    logic [7:0]  s_in_green = 0;
    logic [7:0]  s_in_blue = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [31:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [7:0]  m_out_red;
    logic [7:0]  m_out_green;
    logic [7:0]  m_out_blue;
    logic        m_last_of_run;
    logic        m_frame_end;

    int fail_count;
    int pending;
    int cycles = 0;
    int pixels_sent = 0;
    bit tx_burst = 0;    // sender offers back to back
    bit rx_burst = 0;    // receiver never idles
    bit stall_done = 0;
    int stall_left = 0;
    int rx_count = 0;

    always #4 aclk = ~aclk;

    rgb_median_filter_3x3 u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_red(s_in_red), .s_in_green(s_in_green), .s_in_blue(s_in_blue),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green), .m_out_blue(m_out_blue),
        .m_last_of_run(m_last_of_run), .m_frame_end(m_frame_end)
    );

    rmf_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_red(s_in_red), .s_in_green(s_in_green), .s_in_blue(s_in_blue),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green), .m_out_blue(m_out_blue),
        .m_last_of_run(m_last_of_run), .m_frame_end(m_frame_end),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random back-pressure per output, one long hold partway through
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            rx_count++;
            if (rx_count % 60 == 0) rx_burst = ~rx_burst;
            stall_left = rx_burst ? 0 : $urandom_range(0, 19);
        end
        // long hold so the job queue fills and the input side stalls
        if (!stall_done && pixels_sent >= 100) begin
            stall_done = 1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // offer one pixel transaction after a random gap unless tx_burst is set, return once accepted
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_red   <= r;
        s_in_green <= g;
        s_in_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // stop offering and wait until every predicted output has left
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // register write transaction, only called with the filter drained
    task automatic write_reg(input logic [31:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_channel(), rand_channel(), rand_channel());
    endtask

    logic [7:0] edge_vals[9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFF};

    initial begin
        int w, h, n, random_sent;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest frame, extreme channel values, each channel rotated
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(edge_vals[i], edge_vals[(i + 3) % 9], edge_vals[(i + 6) % 9]);
        drain();

        // below-range sizes clamp to 3, unused register index is ignored
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 32'hFFFF_E001);
        write_reg(32'd2, $urandom);
        send_random(9);
        drain();

        // wide row: two rows plus a few pixels, back to back
        tx_burst = 1;
        write_reg(CFG_WIDTH, 64);
        write_reg(CFG_HEIGHT, 3);
        send_random(2 * 64 + 5);
        drain();

        // above-range width is written then replaced by 3, tallest frame via above-range height
        write_reg(CFG_WIDTH, 32'hFFFF_FFFF);
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 32'hFFFF_FFFF);
        tx_burst = 0;
        send_random(36);
        drain();
        write_reg(CFG_HEIGHT, MAX_HEIGHT);
        send_random(12);
        drain();

        // random small frames, some cut short by a restart
        random_sent = 0;
        while (random_sent < 190) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            tx_burst = ($urandom_range(0, 3) == 0);
            write_reg(CFG_WIDTH, {$urandom} << WIDTH_W | w);
            write_reg(CFG_HEIGHT, {$urandom} << HEIGHT_W | h);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h) : w * h;
            send_random(n);
            random_sent += n;
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
